// ===== rtl/spim0_pkg.sv =====
// Package for the mode 0 SPI master: command codes, word sizing, FSM states
// and the control/status structs between controller and datapath.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package spim0_pkg;

	// Width of one serial word and of the byte-wide item fields.
	localparam int BitsPerWord = 8;
	localparam int DataW       = 8;
	localparam int CmdW        = 3;
	localparam int HalfW       = 8;
	localparam int BitCntW     = ($clog2(BitsPerWord) > 0) ? $clog2(BitsPerWord) : 1;

	typedef logic [BitsPerWord-1:0] word_t;
	typedef logic [DataW-1:0]       data_t;
	typedef logic [CmdW-1:0]        cmd_code_t;
	typedef logic [HalfW-1:0]       half_t;
	typedef logic [BitCntW-1:0]     bit_cnt_t;

	// Command codes; codes five to seven are no-ops.
	localparam cmd_code_t CmdSelect   = 3'd0;
	localparam cmd_code_t CmdDeselect = 3'd1;
	localparam cmd_code_t CmdExchange = 3'd2;
	localparam cmd_code_t CmdSend     = 3'd3;
	localparam cmd_code_t CmdReceive  = 3'd4;

	localparam bit_cnt_t LastBit = BitCntW'(BitsPerWord - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HIGH,
		ST_LOW,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;       // command beat accepted this cycle
		logic phase_step;  // advance the counter of the current SCK phase
		logic enter_low;   // end of the high phase: drop SCK
		logic bit_end;     // end of the low phase: sample MISO, next bit
		logic result_load; // move the finished result into the output register
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_xfer;  // incoming command runs a word transfer
		logic phase_last;  // last cycle of the current SCK phase
		logic bit_last;    // current bit is the last of the word
	} dp_stat_t;

endpackage

// ===== rtl/spim0_if.sv =====
// Handshake interfaces for the SPI master: command, result and configuration.
// Depends on spim0_pkg for the payload types.

interface spim0_cmd_if;
	logic                 valid;
	logic                 ready;
	spim0_pkg::cmd_code_t command;
	spim0_pkg::data_t     tx_byte;
	spim0_pkg::data_t     miso_bits;

	modport source (output valid, output command, output tx_byte, output miso_bits,
		input ready);
	modport sink (input valid, input command, input tx_byte, input miso_bits,
		output ready);
endinterface

interface spim0_rsp_if;
	logic             valid;
	logic             ready;
	spim0_pkg::data_t rx_byte;
	logic             select_active;

	modport source (output valid, output rx_byte, output select_active, input ready);
	modport sink (input valid, input rx_byte, input select_active, output ready);
endinterface

interface spim0_cfg_if;
	logic             valid;
	logic             ready;
	spim0_pkg::half_t half_period_cycles;

	modport source (output valid, output half_period_cycles, input ready);
	modport sink (input valid, input half_period_cycles, output ready);
endinterface

// ===== rtl/spim0_ctrl.sv =====
// Controller FSM of the SPI master: sequences SCK phases and bits, owns the
// command and result handshakes. Depends on spim0_pkg.
module spim0_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  spim0_pkg::dp_stat_t stat,
	output spim0_pkg::dp_ctrl_t ctrl
);

	spim0_pkg::state_t state_q, state_d;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spim0_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.result_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		cmd_ready = 1'b0;
		case (state_q)
			spim0_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctrl.start = 1'b1;
					state_d    = stat.start_xfer ? spim0_pkg::ST_HIGH : spim0_pkg::ST_DONE;
				end
			end
			spim0_pkg::ST_HIGH: begin
				if (stat.phase_last) begin
					ctrl.enter_low = 1'b1;
					state_d        = spim0_pkg::ST_LOW;
				end else begin
					ctrl.phase_step = 1'b1;
				end
			end
			spim0_pkg::ST_LOW: begin
				if (stat.phase_last) begin
					ctrl.bit_end = 1'b1;
					state_d      = stat.bit_last ? spim0_pkg::ST_DONE : spim0_pkg::ST_HIGH;
				end else begin
					ctrl.phase_step = 1'b1;
				end
			end
			spim0_pkg::ST_DONE: begin
				// Wait here while the previous result still sits unclaimed.
				if (!out_valid_q || rsp_ready) begin
					ctrl.result_load = 1'b1;
					state_d          = spim0_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spim0_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	a_ctl_cmd_only: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.start && !stat.start_xfer) |=> (state_q == spim0_pkg::ST_DONE))
		else $error("chip select command did not go straight to result");

	a_last_bit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.bit_end && stat.bit_last) |=> (state_q == spim0_pkg::ST_DONE))
		else $error("transfer did not end after the last bit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready) |-> !ctrl.result_load)
		else $error("pending result overwritten");

endmodule

// ===== rtl/spim0_dp.sv =====
// Datapath of the SPI master: chip select, SCK, shift registers, phase and
// bit counters, divider register and the result register. Depends on spim0_pkg.
module spim0_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spim0_pkg::dp_ctrl_t  ctrl,
	output spim0_pkg::dp_stat_t  stat,
	input  spim0_pkg::cmd_code_t command,
	input  spim0_pkg::data_t     tx_byte,
	input  spim0_pkg::data_t     miso_bits,
	input  logic                 cfg_valid,
	input  spim0_pkg::half_t     cfg_half,
	output spim0_pkg::data_t     rx_byte,
	output logic                 select_active
);

	spim0_pkg::half_t     half_q;
	spim0_pkg::half_t     phase_q;
	spim0_pkg::half_t     phase_end;
	spim0_pkg::bit_cnt_t  bit_q;
	logic                 cs_n_q;
	logic                 sck_q;
	spim0_pkg::word_t     tx_sr_q;   // MSB is the MOSI line
	spim0_pkg::word_t     miso_sr_q;
	spim0_pkg::word_t     rx_sr_q;
	logic                 keep_rx_q;
	spim0_pkg::data_t     rx_out_q;
	logic                 sel_out_q;
	logic                 is_xfer;

	assign is_xfer = (command == spim0_pkg::CmdExchange) || (command == spim0_pkg::CmdSend)
		|| (command == spim0_pkg::CmdReceive);

	// A divider of zero runs as one.
	assign phase_end = (half_q == '0) ? '0 : half_q - 1'b1;

	assign stat.start_xfer = is_xfer;
	assign stat.phase_last = (phase_q == phase_end);
	assign stat.bit_last   = (bit_q == spim0_pkg::LastBit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= spim0_pkg::HalfW'(1);
			phase_q <= '0;
			bit_q   <= '0;
			cs_n_q  <= 1'b1;
			sck_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				half_q <= cfg_half;
			end
			if (ctrl.start) begin
				phase_q <= '0;
				bit_q   <= '0;
				sck_q   <= is_xfer;
				if (command == spim0_pkg::CmdSelect) begin
					cs_n_q <= 1'b0;
				end else if (command == spim0_pkg::CmdDeselect) begin
					cs_n_q <= 1'b1;
				end
			end else if (ctrl.phase_step) begin
				phase_q <= phase_q + 1'b1;
			end else if (ctrl.enter_low) begin
				phase_q <= '0;
				sck_q   <= 1'b0;
			end else if (ctrl.bit_end) begin
				phase_q <= '0;
				if (stat.bit_last) begin
					bit_q <= '0;
				end else begin
					bit_q <= bit_q + 1'b1;
					sck_q <= 1'b1;
				end
			end
		end
	end

	// A select, deselect, send or unused code clears the keep flag at start, so its
	// result carries a zero byte.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			tx_sr_q   <= (command == spim0_pkg::CmdReceive) ? '0 : spim0_pkg::word_t'(tx_byte);
			miso_sr_q <= spim0_pkg::word_t'(miso_bits);
			rx_sr_q   <= '0;
			keep_rx_q <= (command == spim0_pkg::CmdExchange)
				|| (command == spim0_pkg::CmdReceive);
		end else if (ctrl.bit_end) begin
			tx_sr_q   <= tx_sr_q << 1;
			miso_sr_q <= miso_sr_q << 1;
			rx_sr_q   <= {rx_sr_q[spim0_pkg::BitsPerWord-2:0],
				miso_sr_q[spim0_pkg::BitsPerWord-1]};
		end
		if (ctrl.result_load) begin
			rx_out_q  <= keep_rx_q ? spim0_pkg::DataW'(rx_sr_q) : '0;
			sel_out_q <= !cs_n_q;
		end
	end

	assign rx_byte       = rx_out_q;
	assign select_active = sel_out_q;

	a_sck_low_at_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.result_load |-> !sck_q)
		else $error("SCK not idle low at end of command");

	a_sck_falls: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enter_low |=> (!sck_q && (phase_q == '0)))
		else $error("SCK did not fall at end of high phase");

endmodule

// ===== rtl/spi_master_mode0_byte_unit.sv =====
// Top level of the mode 0 SPI master: joins the controller FSM and the datapath
// to the command, result and configuration channels. Depends on spim0_pkg,
// the spim0 interfaces, spim0_ctrl and spim0_dp.
//
//   channel  modport  payload                           beat taken when
//   cmd      sink     command, tx_byte, miso_bits       cmd.valid && cmd.ready
//   rsp      source   rx_byte, select_active            rsp.valid && rsp.ready
//   cfg      sink     half_period_cycles                cfg.valid && cfg.ready
//
// A transfer command shifts eight bits, with H the half period (zero counts
// as one). Select, deselect and unused codes go straight from their beat to
// the result. The SCK phase counter in the datapath paces a transfer: each of
// the eight bits spends one half period high and one half period low, and
// MISO is sampled after the low phase. Reset (arst_n low) releases chip select,
// parks SCK low and sets H to one. The result sits in an output register; a
// new command beat is taken while it waits, and only the next result waits in
// the controller until it is claimed.
module spi_master_mode0_byte_unit (
	input logic       clk,
	input logic       arst_n,
	spim0_cmd_if.sink cmd,
	spim0_rsp_if.source rsp,
	spim0_cfg_if.sink cfg
);

	spim0_pkg::dp_ctrl_t ctrl;
	spim0_pkg::dp_stat_t stat;

	// Configuration is taken on any cycle; it is to be written only while idle, which the block itself does not enforce.
	assign cfg.ready = 1'b1;

	spim0_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	spim0_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.command       (cmd.command),
		.tx_byte       (cmd.tx_byte),
		.miso_bits     (cmd.miso_bits),
		.cfg_valid     (cfg.valid),
		.cfg_half      (cfg.half_period_cycles),
		.rx_byte       (rsp.rx_byte),
		.select_active (rsp.select_active)
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the mode 0 SPI master unit.
// Depends on spim0_pkg, the spim0 interfaces and spi_master_mode0_byte_unit in rtl/.
// Predicts each result beat from the command beats and compares field by field.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// The run sends items at the fastest divider, and the slow divider phases
	// add more time on top of them. This ceiling is many times the slowest
	// legal run, stalls included.
	localparam int unsigned CycleLimit = 1_000_000;

	// One expected result beat.
	typedef struct {
		spim0_pkg::data_t rx_byte;
		logic             select_active;
	} spi_result_t;

	logic clk;
	logic arst_n;

	spim0_cmd_if cmd_ch ();
	spim0_rsp_if rsp_ch ();
	spim0_cfg_if cfg_ch ();

	spi_master_mode0_byte_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Results that the accepted command beats will produce, oldest first.
	spi_result_t pending_results[$];

	// Shadow of the block's state as seen from its ports. The chip select
	// flag is the only state that shows in a result; the half period is kept
	// to size the wait at the end of the run.
	bit               cs_asserted_model;
	spim0_pkg::half_t half_period_model;

	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned cycle_count;

	// Idling controls, written only by the test sequence.
	bit          source_gaps;
	bit          sink_stalls;
	int unsigned hold_requests;
	int unsigned hold_length;

	// 10 ns clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every mismatch goes through here so that it is printed once and counted.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Work out the result of one command and advance the chip select shadow.
	// The bus master never looks at chip select, so a transfer while
	// deselected samples MISO just as it does while selected. Send only
	// throws the sampled word away, and the unused codes five to seven leave
	// everything alone.
	function automatic spi_result_t predict_spi_result(input spim0_pkg::cmd_code_t code,
		input spim0_pkg::data_t miso);
		spi_result_t res;
		res.rx_byte = '0;
		case (code)
			spim0_pkg::CmdSelect:   cs_asserted_model = 1'b1;
			spim0_pkg::CmdDeselect: cs_asserted_model = 1'b0;
			spim0_pkg::CmdExchange: res.rx_byte = miso;
			spim0_pkg::CmdReceive:  res.rx_byte = miso;
			default: begin
			end
		endcase
		res.select_active = cs_asserted_model;
		return res;
	endfunction

	// Monitor: everything is sampled at the rising edge, before the block's
	// registers update. A result beat is checked before the command beat of
	// the same edge is predicted; a command passes the controller's done state and
	// the output register before its result shows, so the two never belong together.
	always @(posedge clk) begin
		spi_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result beat %0d with no command waiting",
						results_checked));
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.rx_byte !== want.rx_byte)
						report_mismatch($sformatf("result %0d rx_byte %02h, want %02h",
							results_checked, rsp_ch.rx_byte, want.rx_byte));
					if (rsp_ch.select_active !== want.select_active)
						report_mismatch($sformatf("result %0d select_active %b, want %b",
							results_checked, rsp_ch.select_active, want.select_active));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				pending_results.push_back(predict_spi_result(cmd_ch.command,
					cmd_ch.miso_bits));
			if (cfg_ch.valid && cfg_ch.ready)
				half_period_model = cfg_ch.half_period_cycles;
		end
	end

	// Result side ready. Outside a hold it is either always high or low in
	// about a third of the cycles. A hold is asked for by bumping
	// hold_requests; the countdown itself lives only in this process.
	initial begin
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left = 0;
		holds_served = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = hold_length;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (sink_stalls) begin
				rsp_ch.ready <= ($urandom_range(99) >= 34);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("spi_master_mode0_byte_unit regression: fail");
			$finish;
		end
	end

	// Offer one command beat and hold it until the block takes it. Entered and
	// left at a falling edge. Valid is not dropped after a beat unless a gap
	// follows, so back-to-back beats keep it high without a glitch.
	task automatic send_spi_command(input spim0_pkg::cmd_code_t code,
		input spim0_pkg::data_t tx, input spim0_pkg::data_t miso);
		while (source_gaps && ($urandom_range(99) < 34)) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.command   <= code;
		cmd_ch.tx_byte   <= tx;
		cmd_ch.miso_bits <= miso;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Stop offering commands and wait for every outstanding result.
	task automatic wait_for_results;
		cmd_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	// Write the half period. Only called with nothing in flight.
	task automatic write_half_period(input spim0_pkg::half_t value);
		cfg_ch.half_period_cycles <= value;
		cfg_ch.valid              <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random traffic. Most of it is framed transactions: select, a few word
	// transfers of random kind and content, then deselect (sometimes left
	// out so that the next frame starts already selected). The rest is
	// single commands with a fully random code, unused codes among them,
	// which also gives transfers while deselected.
	task automatic send_random_items(input int unsigned count);
		int unsigned          sent;
		int unsigned          burst;
		spim0_pkg::cmd_code_t code;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 85) begin
				send_spi_command(spim0_pkg::CmdSelect, spim0_pkg::data_t'($urandom),
					spim0_pkg::data_t'($urandom));
				sent++;
				burst = $urandom_range(6, 1);
				repeat (burst) begin
					case ($urandom_range(2))
						0: code = spim0_pkg::CmdExchange;
						1: code = spim0_pkg::CmdSend;
						default: code = spim0_pkg::CmdReceive;
					endcase
					send_spi_command(code, spim0_pkg::data_t'($urandom),
						spim0_pkg::data_t'($urandom));
					sent++;
				end
				if ($urandom_range(99) < 80) begin
					send_spi_command(spim0_pkg::CmdDeselect, spim0_pkg::data_t'($urandom),
						spim0_pkg::data_t'($urandom));
					sent++;
				end
			end else begin
				send_spi_command(spim0_pkg::cmd_code_t'($urandom_range(7)),
					spim0_pkg::data_t'($urandom), spim0_pkg::data_t'($urandom));
				sent++;
			end
		end
	endtask

	// Every command at the reset divider, with the byte extremes, unused
	// codes while selected and deselected, repeated select and deselect, and
	// transfers with chip select released.
	task automatic test_directed_commands;
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		send_spi_command(spim0_pkg::CmdExchange, 8'hA5, 8'h3C);
		send_spi_command(spim0_pkg::CmdSelect,   8'h00, 8'h00);
		send_spi_command(spim0_pkg::CmdExchange, 8'hFF, 8'hFF);
		send_spi_command(spim0_pkg::CmdExchange, 8'h00, 8'h00);
		send_spi_command(spim0_pkg::CmdExchange, 8'hA5, 8'h5A);
		send_spi_command(spim0_pkg::CmdSend,     8'hFF, 8'hFF);
		send_spi_command(spim0_pkg::CmdSend,     8'h00, 8'hA5);
		send_spi_command(spim0_pkg::CmdReceive,  8'hFF, 8'h81);
		send_spi_command(spim0_pkg::CmdReceive,  8'h00, 8'h7E);
		send_spi_command(3'd5,                   8'hFF, 8'hFF);
		send_spi_command(spim0_pkg::CmdSelect,   8'hFF, 8'hFF);
		send_spi_command(spim0_pkg::CmdDeselect, 8'hFF, 8'hFF);
		send_spi_command(spim0_pkg::CmdDeselect, 8'h00, 8'h00);
		send_spi_command(3'd6,                   8'h55, 8'hAA);
		send_spi_command(3'd7,                   8'hFF, 8'hFF);
		send_spi_command(spim0_pkg::CmdReceive,  8'h00, 8'hC3);
		send_spi_command(spim0_pkg::CmdSend,     8'h3C, 8'h96);
		wait_for_results();
	endtask

	// Zero half period, which must act as one, then the slowest divider with
	// a couple of transfers, then back to the fastest.
	task automatic test_half_period_extremes;
		write_half_period(8'd0);
		send_spi_command(spim0_pkg::CmdSelect,   8'h12, 8'h34);
		send_spi_command(spim0_pkg::CmdExchange, 8'h80, 8'h01);
		send_spi_command(spim0_pkg::CmdReceive,  8'hFF, 8'hFE);
		send_spi_command(spim0_pkg::CmdDeselect, 8'h00, 8'h00);
		wait_for_results();
		write_half_period(8'd255);
		send_spi_command(spim0_pkg::CmdSelect,   8'h00, 8'h00);
		send_spi_command(spim0_pkg::CmdExchange, 8'h96, 8'hE7);
		send_spi_command(spim0_pkg::CmdReceive,  8'h00, 8'h18);
		send_spi_command(spim0_pkg::CmdDeselect, 8'h00, 8'h00);
		wait_for_results();
		write_half_period(8'd1);
	endtask

	// A long stretch with no idling on either side at the fastest divider.
	task automatic test_back_to_back;
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		send_random_items(200);
		wait_for_results();
	endtask

	// The result side holds off for a long stretch while commands keep
	// coming, so the output register and the controller fill and the command
	// channel stalls. Everything must drain in order once ready returns.
	task automatic test_output_backpressure;
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		write_half_period(8'd1);
		hold_length = 400;
		hold_requests++;
		send_random_items(60);
		wait_for_results();
	endtask

	// Random traffic with idling on both sides over a series of dividers.
	// Slow dividers get few items so the run stays short.
	task automatic test_random_traffic;
		int unsigned      phase;
		int unsigned      count;
		spim0_pkg::half_t half;
		source_gaps = 1'b1;
		sink_stalls = 1'b1;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin half = 8'd1; count = 200; end
				1: begin half = 8'd0; count = 170; end
				2: begin half = 8'd2; count = 170; end
				3: begin half = spim0_pkg::half_t'($urandom_range(8, 3));  count = 170; end
				4: begin half = spim0_pkg::half_t'($urandom_range(40, 9)); count = 60;  end
				5: begin half = 8'd255; count = 3; end
				default: begin
					half  = spim0_pkg::half_t'($urandom_range(4, 1));
					count = (phase == 6) ? 200 : 220;
				end
			endcase
			write_half_period(half);
			send_random_items(count);
			wait_for_results();
		end
	endtask

	initial begin
		int unsigned tail_cycles;
		arst_n                    = 1'b0;
		cmd_ch.valid              = 1'b0;
		cmd_ch.command            = spim0_pkg::CmdSelect;
		cmd_ch.tx_byte            = '0;
		cmd_ch.miso_bits          = '0;
		cfg_ch.valid              = 1'b0;
		cfg_ch.half_period_cycles = '0;
		source_gaps               = 1'b0;
		sink_stalls               = 1'b0;
		hold_requests             = 0;
		hold_length               = 0;
		mismatch_count            = 0;
		results_checked           = 0;
		cycle_count               = 0;
		cs_asserted_model         = 1'b0;
		half_period_model         = 8'd1;

		// Reset is held from time zero and released on a falling edge.
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_directed_commands();
		test_half_period_extremes();
		test_back_to_back();
		test_output_backpressure();
		test_random_traffic();

		// Nothing should come out once the last result is in. Give the
		// block one full transfer time at the current divider to prove it.
		wait_for_results();
		tail_cycles = 2 + 16 * ((half_period_model == 0) ? 1 : half_period_model) + 8;
		repeat (tail_cycles) @(negedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		if (mismatch_count == 0) begin
			$display("spi_master_mode0_byte_unit regression: pass");
		end else begin
			$display("spi_master_mode0_byte_unit regression: fail");
		end
		$finish;
	end

endmodule
